// File: hw/rtl/bbd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bbd_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int HEIGHT_MAX  = 4096;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(HEIGHT_MAX);
    localparam int FW_W        = 11;
    localparam int FH_W        = 13;
    localparam int PIX_W       = 8;
    localparam int SUM_W       = PIX_W + 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 13;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    // Division by three as multiply by 683 and shift by 11; exact below 1024.
    localparam int RECIP3       = 683;
    localparam int RECIP3_SHIFT = 11;

    typedef struct packed {
        logic [COL_W-1:0] slot;
        logic [PIX_W-1:0] val;
        logic             emit;
        logic             has_l;
        logic             has_r;
        logic             has_u;
        logic             has_d;
        logic             even_row;
        logic             even_col;
        logic             last;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    function automatic logic [PIX_W-1:0] mean_div(input logic [SUM_W-1:0] sum,
                                                  input logic [2:0] cnt);
        logic [SUM_W+RECIP3_SHIFT-1:0] prod;
        logic [PIX_W-1:0]              res;
        prod = (SUM_W + RECIP3_SHIFT)'(sum) * (SUM_W + RECIP3_SHIFT)'(RECIP3);
        case (cnt)
            3'd1: res = sum[PIX_W-1:0];
            3'd2: res = sum[PIX_W:1];
            3'd3: res = prod[RECIP3_SHIFT +: PIX_W];
            3'd4: res = sum[PIX_W+1:2];
            default: res = '0;
        endcase
        return res;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/bbd_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface bbd_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] raw_value;
    modport source (output valid, action, raw_value, input ready);
    modport sink (input valid, action, raw_value, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/bbd_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface bbd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_end;
    modport source (output valid, red, green, blue, frame_end, input ready);
    modport sink (input valid, red, green, blue, frame_end, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/bbd_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface bbd_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [12:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/bbd_front.sv
`timescale 1ns / 1ps
`default_nettype none
module bbd_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    bbd_in_if.sink                    pixels,
    bbd_cfg_if.sink                   cfg,
    input  wire logic                 q_full,
    output logic                      push,
    output bbd_pkg::cmd_t             cmd
);
    import bbd_pkg::*;

    logic [FW_W-1:0]  frame_width_reg;
    logic [FH_W-1:0]  frame_height_reg;
    logic [FW_W-1:0]  w;
    logic [FH_W-1:0]  h;
    logic [COL_W-1:0] in_col_reg, in_col_next;
    logic [FH_W-1:0]  in_row_reg, in_row_next;
    logic [COL_W-1:0] out_col_reg, out_col_next;
    logic [ROW_W-1:0] out_row_reg, out_row_next;
    logic             accept, draining, ignore, emit, col_wrap, out_wrap, out_rowend;
    logic             last;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FW_W'(160);
            frame_height_reg <= FH_W'(120);
        end
        else if (cfg.valid)
        begin
            if (cfg.index == REG_FRAME_WIDTH)
                frame_width_reg <= cfg.data[FW_W-1:0];
            else if (cfg.index == REG_FRAME_HEIGHT)
                frame_height_reg <= cfg.data;
        end
    end

    always_comb
    begin
        if (frame_width_reg < FW_W'(3))
            w = FW_W'(3);
        else if (frame_width_reg > FW_W'(MAX_WIDTH))
            w = FW_W'(MAX_WIDTH);
        else
            w = frame_width_reg;
        if (frame_height_reg < FH_W'(3))
            h = FH_W'(3);
        else if (frame_height_reg > FH_W'(HEIGHT_MAX))
            h = FH_W'(HEIGHT_MAX);
        else
            h = frame_height_reg;
    end

    assign pixels.ready = !q_full;
    assign accept   = pixels.valid && !q_full;
    assign draining = in_row_reg >= h;
    assign ignore   = (pixels.action == ACT_FLUSH) && !draining;
    assign push     = accept && !ignore;
    assign emit     = (in_row_reg >= FH_W'(2))
                   || (in_row_reg == FH_W'(1) && in_col_reg != '0);
    assign col_wrap   = (FW_W'(in_col_reg) + FW_W'(1)) >= w;
    assign out_wrap   = (FW_W'(out_col_reg) + FW_W'(1)) >= w;
    assign out_rowend = (FH_W'(out_row_reg) + FH_W'(1)) >= h;
    assign last       = out_wrap && out_rowend;

    always_comb
    begin
        cmd.slot     = in_col_reg;
        cmd.val      = draining ? '0 : pixels.raw_value;
        cmd.emit     = emit;
        cmd.has_l    = out_col_reg != '0;
        cmd.has_r    = !out_wrap;
        cmd.has_u    = out_row_reg != '0;
        cmd.has_d    = !out_rowend;
        cmd.even_row = !out_row_reg[0];
        cmd.even_col = !out_col_reg[0];
        cmd.last     = last;
    end

    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (push)
        begin
            if (col_wrap)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + FH_W'(1);
            end
            else
                in_col_next = in_col_reg + COL_W'(1);
            if (emit)
            begin
                if (last)
                begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end
                else if (out_wrap)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + ROW_W'(1);
                end
                else
                    out_col_next = out_col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else
        begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/bbd_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module bbd_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire bbd_pkg::cmd_t  push_cmd,
    input  wire logic           pop,
    output bbd_pkg::cmd_t       head,
    output bbd_pkg::queue_stat_t stat
);
    import bbd_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic              do_push, do_pop;

    assign stat.full  = count_reg == (QPTR_W+1)'(QUEUE_DEPTH);
    assign stat.empty = count_reg == '0;
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head       = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + (QPTR_W+1)'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - (QPTR_W+1)'(1);
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/bbd_back.sv
`timescale 1ns / 1ps
`default_nettype none
module bbd_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire bbd_pkg::cmd_t        head,
    input  wire bbd_pkg::queue_stat_t stat,
    output logic                      pop,
    bbd_out_if.source                 rgb
);
    import bbd_pkg::*;

    // Each line-store entry holds the older row above the newer row.
    logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] rd_data_reg;
    logic [PIX_W-1:0]   win_reg [3][3];
    cmd_t               s1_reg, s2_reg;
    logic               s1_valid_reg, s2_valid_reg;
    logic               out_valid_reg;
    logic [PIX_W-1:0]   red_reg, green_reg, blue_reg;
    logic               frame_end_reg;
    logic               advance;

    logic [SUM_W-1:0]   hs, vs, ds, gs;
    logic [2:0]         hn, vn, dn, gn;
    logic [PIX_W-1:0]   own, m_h, m_v, m_d, m_g;
    logic [PIX_W-1:0]   red_next, green_next, blue_next;

    assign advance = !out_valid_reg || rgb.ready;
    assign pop     = advance && !stat.empty;

    always_ff @(posedge clk)
    begin
        if (pop)
            rd_data_reg <= line_mem[head.slot];
        if (advance && s1_valid_reg)
            line_mem[s1_reg.slot] <= {rd_data_reg[PIX_W-1:0], s1_reg.val};
        if (pop)
            s1_reg <= head;
        if (advance)
            s2_reg <= s1_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    win_reg[r][c] <= '0;
        end
        else if (advance)
        begin
            s1_valid_reg <= !stat.empty;
            s2_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    win_reg[r][0] <= win_reg[r][1];
                    win_reg[r][1] <= win_reg[r][2];
                end
                win_reg[0][2] <= rd_data_reg[2*PIX_W-1:PIX_W];
                win_reg[1][2] <= rd_data_reg[PIX_W-1:0];
                win_reg[2][2] <= s1_reg.val;
            end
        end
    end

    always_comb
    begin
        hs = '0; vs = '0; ds = '0;
        hn = '0; vn = '0; dn = '0;
        if (s2_reg.has_l)
        begin
            hs = hs + SUM_W'(win_reg[1][0]); hn = hn + 3'd1;
        end
        if (s2_reg.has_r)
        begin
            hs = hs + SUM_W'(win_reg[1][2]); hn = hn + 3'd1;
        end
        if (s2_reg.has_u)
        begin
            vs = vs + SUM_W'(win_reg[0][1]); vn = vn + 3'd1;
        end
        if (s2_reg.has_d)
        begin
            vs = vs + SUM_W'(win_reg[2][1]); vn = vn + 3'd1;
        end
        if (s2_reg.has_u && s2_reg.has_l)
        begin
            ds = ds + SUM_W'(win_reg[0][0]); dn = dn + 3'd1;
        end
        if (s2_reg.has_u && s2_reg.has_r)
        begin
            ds = ds + SUM_W'(win_reg[0][2]); dn = dn + 3'd1;
        end
        if (s2_reg.has_d && s2_reg.has_l)
        begin
            ds = ds + SUM_W'(win_reg[2][0]); dn = dn + 3'd1;
        end
        if (s2_reg.has_d && s2_reg.has_r)
        begin
            ds = ds + SUM_W'(win_reg[2][2]); dn = dn + 3'd1;
        end
        gs  = hs + vs;
        gn  = hn + vn;
        own = win_reg[1][1];
        m_h = mean_div(hs, hn);
        m_v = mean_div(vs, vn);
        m_d = mean_div(ds, dn);
        m_g = mean_div(gs, gn);
        case ({s2_reg.even_row, s2_reg.even_col})
            2'b11:
            begin
                red_next = own; green_next = m_g; blue_next = m_d;
            end
            2'b00:
            begin
                red_next = m_d; green_next = m_g; blue_next = own;
            end
            2'b10:
            begin
                red_next = m_h; green_next = own; blue_next = m_v;
            end
            default:
            begin
                red_next = m_v; green_next = own; blue_next = m_h;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            red_reg       <= red_next;
            green_reg     <= green_next;
            blue_reg      <= blue_next;
            frame_end_reg <= s2_reg.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= s2_valid_reg && s2_reg.emit;
    end

    assign rgb.valid     = out_valid_reg;
    assign rgb.red       = red_reg;
    assign rgb.green     = green_reg;
    assign rgb.blue      = blue_reg;
    assign rgb.frame_end = frame_end_reg;

endmodule
`default_nettype wire

// File: hw/rtl/bayer_bilinear_demosaic.sv
// Bilinear demosaic of an RGGB Bayer stream, one raw sample per word.
// Channels: pixels (action, raw_value) in, rgb (red, green, blue,
// frame_end) out, cfg writes frame_width (index 0) and frame_height
// (index 1). Configuration must be written only while the block is idle;
// the block itself does not enforce this. A word is taken on every cycle
// in which the pixel queue has room, so while the receiver keeps up the
// sustained rate is one word per clock. A result appears one frame line
// plus one word after its own sample; the result a word completes passes
// the queue, the line-store read, the window shift and the output register.
// The line stores are one 1024 x 16 memory, read once and written once
// per word, which sets the one-word-per-clock figure.
// Flush words before the last pixel of a frame are dropped; after it they
// drain the final row. A stalled receiver holds the output register, the
// back pipeline freezes, and once the four-entry queue fills pixels.ready
// falls. Reset clears the counters, the window and all valid flags and
// restores the sizes to 160 x 120; the line stores are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module bayer_bilinear_demosaic (
    input wire logic  clk,
    input wire logic  rst_n,
    bbd_in_if.sink    pixels,
    bbd_out_if.source rgb,
    bbd_cfg_if.sink   cfg
);
    import bbd_pkg::*;

    cmd_t        push_cmd, head;
    queue_stat_t q_stat;
    logic        push, pop;

    bbd_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .pixels (pixels),
        .cfg    (cfg),
        .q_full (q_stat.full),
        .push   (push),
        .cmd    (push_cmd)
    );

    bbd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .stat     (q_stat)
    );

    bbd_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .stat  (q_stat),
        .pop   (pop),
        .rgb   (rgb)
    );

    a_queue_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue reports full and empty together");

    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (push && q_stat.empty) |=> !q_stat.empty)
        else $error("pushed word missing from queue");

    a_stall_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (rgb.valid && !rgb.ready) |-> !pop)
        else $error("queue popped while output stalled");

    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.full |-> !pixels.ready)
        else $error("pixel word accepted into a full queue");

endmodule
`default_nettype wire

// File: tb/bbd_checker.sv
`timescale 1ns / 1ps
module bbd_checker
    import bbd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    bbd_in_if    pixels,
    bbd_out_if   rgb,
    bbd_cfg_if   cfg,
    output int   errors,
    output int   outstanding
);

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       frame_end;
    } rgb_word_t;

    rgb_word_t      expected_rgb[$];
    logic [FW_W-1:0] width_reg;
    logic [FH_W-1:0] height_reg;
    logic [7:0]      older_line[MAX_WIDTH];
    logic [7:0]      newer_line[MAX_WIDTH];
    logic [7:0]      win[3][3];
    int              in_col, in_row, out_col, out_row;

    function automatic int clamp_size(input int v, input int hi);
        if (v < 3) return 3;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int avg(input int sum, input int cnt);
        return (cnt == 0) ? 0 : sum / cnt;
    endfunction

    // Advances the line stores and window by one word and queues the
    // colour triple that comes out of it, if any.
    function automatic void demosaic_step(input logic act, input logic [7:0] raw);
        int        w, h, slot;
        bit        draining, emit, hl, hr, hu, hd, er, ec;
        int        hs, hn, vs, vn, ds, dn;
        rgb_word_t res;
        logic [7:0] v;
        w = clamp_size(int'(width_reg), MAX_WIDTH);
        h = clamp_size(int'(height_reg), HEIGHT_MAX);
        draining = in_row >= h;
        v = raw;
        hs = 0; hn = 0; vs = 0; vn = 0; ds = 0; dn = 0;
        if (act == ACT_FLUSH && !draining)
            return;
        if (draining)
            v = 8'd0;
        slot = in_col % MAX_WIDTH;
        for (int r = 0; r < 3; r++)
        begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
        end
        win[0][2] = older_line[slot];
        win[1][2] = newer_line[slot];
        win[2][2] = v;
        older_line[slot] = newer_line[slot];
        newer_line[slot] = v;
        emit = in_row >= 2 || (in_row == 1 && in_col >= 1);
        if (in_col + 1 >= w)
        begin
            in_col = 0;
            in_row++;
        end
        else
            in_col++;
        if (!emit)
            return;
        hl = out_col > 0;
        hr = out_col + 1 < w;
        hu = out_row > 0;
        hd = out_row + 1 < h;
        if (hl) begin hs += win[1][0]; hn++; end
        if (hr) begin hs += win[1][2]; hn++; end
        if (hu) begin vs += win[0][1]; vn++; end
        if (hd) begin vs += win[2][1]; vn++; end
        if (hu && hl) begin ds += win[0][0]; dn++; end
        if (hu && hr) begin ds += win[0][2]; dn++; end
        if (hd && hl) begin ds += win[2][0]; dn++; end
        if (hd && hr) begin ds += win[2][2]; dn++; end
        er = (out_row % 2) == 0;
        ec = (out_col % 2) == 0;
        if (er && ec)
        begin
            res.red   = win[1][1];
            res.green = 8'(avg(hs + vs, hn + vn));
            res.blue  = 8'(avg(ds, dn));
        end
        else if (!er && !ec)
        begin
            res.red   = 8'(avg(ds, dn));
            res.green = 8'(avg(hs + vs, hn + vn));
            res.blue  = win[1][1];
        end
        else if (er)
        begin
            res.red   = 8'(avg(hs, hn));
            res.green = win[1][1];
            res.blue  = 8'(avg(vs, vn));
        end
        else
        begin
            res.red   = 8'(avg(vs, vn));
            res.green = win[1][1];
            res.blue  = 8'(avg(hs, hn));
        end
        res.frame_end = (out_row + 1 >= h) && (out_col + 1 >= w);
        expected_rgb.push_back(res);
        if (res.frame_end)
        begin
            in_col = 0;
            in_row = 0;
            out_col = 0;
            out_row = 0;
        end
        else if (out_col + 1 >= w)
        begin
            out_col = 0;
            out_row++;
        end
        else
            out_col++;
    endfunction

    initial
    begin
        for (int i = 0; i < MAX_WIDTH; i++)
        begin
            older_line[i] = 8'd0;
            newer_line[i] = 8'd0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        rgb_word_t exp_w;
        if (!rst_n)
        begin
            errors     = 0;
            width_reg  = FW_W'(160);
            height_reg = FH_W'(120);
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    win[r][c] = 8'd0;
            in_col = 0;
            in_row = 0;
            out_col = 0;
            out_row = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_FRAME_WIDTH:  width_reg  = cfg.data[FW_W-1:0];
                    REG_FRAME_HEIGHT: height_reg = cfg.data[FH_W-1:0];
                    default: ;
                endcase
            end
            if (rgb.valid && rgb.ready)
            begin
                if (expected_rgb.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("Unexpected word: rgb=%0d,%0d,%0d end=%0b",
                                 rgb.red, rgb.green, rgb.blue, rgb.frame_end);
                end
                else
                begin
                    exp_w = expected_rgb.pop_front();
                    if (exp_w.red !== rgb.red || exp_w.green !== rgb.green ||
                        exp_w.blue !== rgb.blue || exp_w.frame_end !== rgb.frame_end)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("Wrong word: expected rgb=%0d,%0d,%0d end=%0b,",
                                     exp_w.red, exp_w.green, exp_w.blue,
                                     exp_w.frame_end,
                                     " got rgb=%0d,%0d,%0d end=%0b",
                                     rgb.red, rgb.green, rgb.blue, rgb.frame_end);
                    end
                end
            end
            if (pixels.valid && pixels.ready)
                demosaic_step(pixels.action, pixels.raw_value);
        end
        outstanding = expected_rgb.size();
    end

endmodule

// File: tb/bayer_bilinear_demosaic_tb.sv
`timescale 1ns / 1ps
module bayer_bilinear_demosaic_tb;
    import bbd_pkg::*;

    logic clk;
    logic rst_n;
    int   errors;
    int   outstanding;
    int   pixels_sent;

    bbd_in_if  pix_ch();
    bbd_out_if rgb_ch();
    bbd_cfg_if cfg_ch();

    bayer_bilinear_demosaic i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pixels (pix_ch),
        .rgb    (rgb_ch),
        .cfg    (cfg_ch)
    );

    bbd_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixels      (pix_ch),
        .rgb         (rgb_ch),
        .cfg         (cfg_ch),
        .errors      (errors),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10ms;
        $display("Mismatches found");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Ready comes only from the queue count register inside the block, so the
    // value sampled at the falling edge is the one the rising edge then sees.
    task automatic send_word(input logic act, input logic [7:0] v);
        int gap;
        bit taken;
        gap = pick_gap();
        if (gap > 0)
        begin
            pix_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_ch.valid     <= 1'b1;
        pix_ch.action    <= act;
        pix_ch.raw_value <= v;
        do
        begin
            @(negedge clk);
            taken = pix_ch.ready;
            @(posedge clk);
        end
        while (!taken);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        bit taken;
        pix_ch.valid <= 1'b0;
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= d;
        do
        begin
            @(negedge clk);
            taken = cfg_ch.ready;
            @(posedge clk);
        end
        while (!taken);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_idle();
        pix_ch.valid <= 1'b0;
        // The checker counts the last accepted word at that same edge.
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        // Ignored flush words are never pushed into the queue.
        repeat (20) @(posedge clk);
    endtask

    // One frame: w*h pixels with stray early flushes, one line plus one word
    // of drain, and a few flushes after the frame end that must be ignored.
    // style 0 random, 1 all full scale, 2 checkerboard of extremes.
    task automatic run_frame(input int w, input int h, input int style, input int stray);
        logic [7:0] v;
        for (int k = 0; k < w * h; k++)
        begin
            if (stray > 0 && $urandom_range(0, stray - 1) == 0)
                send_word(ACT_FLUSH, 8'($urandom));
            case (style)
                1: v = 8'hFF;
                2: v = (((k / w) + (k % w)) % 2 == 0) ? 8'hFF : 8'h00;
                default: v = 8'($urandom);
            endcase
            send_word(ACT_PIXEL, v);
            pixels_sent++;
        end
        for (int k = 0; k <= w; k++)
            send_word($urandom_range(0, 1) ? ACT_FLUSH : ACT_PIXEL, 8'($urandom));
        repeat ($urandom_range(0, 2)) send_word(ACT_FLUSH, 8'($urandom));
        wait_idle();
    endtask

    task automatic set_size(input int w, input int h);
        write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(w));
        write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
    endtask

    initial
    begin
        int w;
        int h;
        rst_n            <= 1'b0;
        pix_ch.valid     <= 1'b0;
        pix_ch.action    <= ACT_PIXEL;
        pix_ch.raw_value <= 8'd0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.index     <= REG_FRAME_WIDTH;
        cfg_ch.data      <= '0;
        pixels_sent = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Smallest frame at full scale, then extremes in a checkerboard.
        set_size(3, 3);
        send_word(ACT_FLUSH, 8'hFF);
        run_frame(3, 3, 1, 0);
        set_size(4, 4);
        run_frame(4, 4, 2, 0);

        // Sizes below the floor are clamped.
        set_size(0, 2);
        run_frame(3, 3, 0, 8);
        write_reg(REG_FRAME_WIDTH, 13'd1);
        write_reg(REG_FRAME_HEIGHT, 13'd0);
        run_frame(3, 3, 0, 4);

        while (pixels_sent < 1100)
        begin
            if ($urandom_range(0, 7) == 0)
                w = $urandom_range(13, 40);
            else
                w = $urandom_range(3, 12);
            h = $urandom_range(3, 10);
            set_size(w, h);
            run_frame(w, h, 0, 16);
        end

        pix_ch.valid <= 1'b0;
        while (outstanding != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        rgb_ch.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            int n;
            n = $urandom_range(0, 9);
            if (n < 3)
            begin
                rgb_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge clk);
            end
            else if (n == 9)
            begin
                rgb_ch.ready <= 1'b0;
                repeat ($urandom_range(8, 30)) @(posedge clk);
            end
            else
            begin
                rgb_ch.ready <= 1'($urandom_range(0, 1));
                @(posedge clk);
            end
        end
    end

endmodule
